[hw/rtl/spce_pkg.sv]
`timescale 1ns / 1ps
package spce_pkg;

  // input kinds
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // configuration register indexes
  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_APP_END = 1'b1;

  // register reset values
  localparam logic [15:0] TIMEOUT_RST = 16'd2000;
  localparam logic [15:0] APP_END_RST = 16'd28672;

  // default geometry
  localparam int PAGE_BYTES_DEF   = 128;
  localparam int FLASH_WORDS_DEF  = 16384;
  localparam int EEPROM_BYTES_DEF = 1024;
  localparam int QUEUE_DEPTH      = 4;

  // protocol characters
  localparam logic [7:0] CH_START  = 8'h53; // 'S'
  localparam logic [7:0] CH_ADDR   = 8'h41; // 'A'
  localparam logic [7:0] CH_BLOAD  = 8'h42; // 'B'
  localparam logic [7:0] CH_BREAD  = 8'h67; // 'g'
  localparam logic [7:0] CH_ERASE  = 8'h65; // 'e'
  localparam logic [7:0] CH_EXIT   = 8'h45; // 'E'
  localparam logic [7:0] CH_SIG    = 8'h73; // 's'
  localparam logic [7:0] CH_FLASH  = 8'h46; // 'F'
  localparam logic [7:0] CH_EEPROM = 8'h45; // 'E'
  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_QM     = 8'h3F;
  localparam logic [7:0] SIG_BYTE  = 8'hD0;
  localparam logic [7:0] ERASED_B  = 8'hFF;
  localparam logic [15:0] ERASED_W = 16'hFFFF;

  typedef enum logic [3:0] {
    K_START, K_CR, K_QM, K_EXIT, K_ADDR, K_SIG, K_ERASE, K_DATA, K_READ
  } kind_t;

  typedef enum logic [1:0] {MK_OTHER, MK_FLASH, MK_EEPROM} mem_kind_t;

  // one queued request for the back end
  typedef struct packed {
    kind_t       kind;
    logic [15:0] arg;   // address, or buffer index for data
    logic [7:0]  size;
    mem_kind_t   mk;
    logic [7:0]  data;
    logic        fin;   // last data byte of a block load
  } cmd_t;

endpackage

[hw/rtl/spce_ram.sv]
`timescale 1ns / 1ps
module spce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/spce_queue.sv]
`timescale 1ns / 1ps
module spce_queue import spce_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t wdata,
  output logic full,
  input  logic pop,
  output cmd_t rdata,
  output logic empty
);

  localparam int AW = $clog2(DEPTH);

  cmd_t             slots [DEPTH];
  logic [AW-1:0]    wptr_r, rptr_r;
  logic [AW:0]      cnt_r;

  assign full  = (cnt_r == (AW+1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = slots[rptr_r];

  // payload slots
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr_r] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == AW'(DEPTH-1)) ? '0 : wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= (rptr_r == AW'(DEPTH-1)) ? '0 : rptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

[hw/rtl/spce_front.sv]
`timescale 1ns / 1ps
module spce_front import spce_pkg::*; #(
  parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  rx_byte,
  input  logic        opcode,
  input  logic [15:0] timeout_ticks,
  input  logic        q_full,
  input  logic        clr_done,
  output logic        push,
  output cmd_t        entry
);

  typedef enum logic [2:0] {
    PH_WAIT_S, PH_WAIT_ID, PH_LOCKED, PH_CMD, PH_ARGS, PH_DATA, PH_DONE
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [15:0] tick_r, tick_nxt, tick_inc;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [1:0]  argi_r, argi_nxt;
  logic [7:0]  size_r, size_nxt;
  logic [7:0]  addr_hi_r, addr_hi_nxt;
  logic [7:0]  didx_r, didx_nxt;
  mem_kind_t   mk_r, mk_nxt;
  logic        acc;
  logic        size_ok;
  logic        data_fin;

  assign in_tready = clr_done && !q_full;
  assign acc       = in_tvalid && in_tready;
  assign tick_inc  = (opcode == OP_TICK && tick_r != 16'hFFFF) ? tick_r + 16'd1 : tick_r;
  assign data_fin  = ({1'b0, didx_r} + 9'd1) >= {1'b0, size_r};

  // size check on the size held so far and the kind decoded from this byte
  always_comb begin
    size_ok = (size_r != 8'd0) && ({1'b0, size_r} <= 9'(PAGE_BYTES));
    if (mk_nxt == MK_FLASH && size_r[0]) begin
      size_ok = 1'b0;
    end
  end

  // command parser
  always_comb begin
    phase_nxt   = phase_r;
    tick_nxt    = tick_r;
    cmd_nxt     = cmd_r;
    argi_nxt    = argi_r;
    size_nxt    = size_r;
    addr_hi_nxt = addr_hi_r;
    didx_nxt    = didx_r;
    mk_nxt      = mk_r;
    push        = 1'b0;
    entry       = '{kind: K_CR, arg: 16'd0, size: size_r, mk: mk_r, data: rx_byte, fin: 1'b0};
    if (acc) begin
      if (phase_r == PH_WAIT_S) begin
        tick_nxt = tick_inc;
        if (tick_inc >= timeout_ticks) begin
          push       = 1'b1;
          entry.kind = K_START;
          phase_nxt  = PH_DONE;
        end else if (opcode == OP_BYTE && rx_byte == CH_START) begin
          phase_nxt = PH_WAIT_ID;
        end
      end else if (opcode == OP_BYTE) begin
        case (phase_r)
          // nothing can have written the EEPROM yet, so its last byte is erased
          PH_WAIT_ID: begin
            if (rx_byte == ERASED_B || rx_byte == 8'd0) begin
              push      = 1'b1;
              phase_nxt = PH_CMD;
            end else begin
              phase_nxt = PH_LOCKED;
            end
          end
          PH_CMD: begin
            case (rx_byte)
              CH_ADDR, CH_BLOAD, CH_BREAD: begin
                cmd_nxt   = rx_byte;
                argi_nxt  = 2'd0;
                phase_nxt = PH_ARGS;
              end
              CH_ERASE: begin
                push       = 1'b1;
                entry.kind = K_ERASE;
              end
              CH_EXIT: begin
                push       = 1'b1;
                entry.kind = K_EXIT;
                phase_nxt  = PH_DONE;
              end
              CH_SIG: begin
                push       = 1'b1;
                entry.kind = K_SIG;
              end
              CH_ESC: begin
              end
              default: begin
                push       = 1'b1;
                entry.kind = K_QM;
              end
            endcase
          end
          PH_ARGS: begin
            if (cmd_r == CH_ADDR) begin
              if (argi_r == 2'd0) begin
                addr_hi_nxt = rx_byte;
                argi_nxt    = 2'd1;
              end else begin
                push       = 1'b1;
                entry.kind = K_ADDR;
                entry.arg  = {addr_hi_r, rx_byte};
                phase_nxt  = PH_CMD;
              end
            end else if (argi_r == 2'd0) begin
              // a nonzero high byte marks a size beyond any page
              size_nxt = (rx_byte != 8'd0) ? 8'hFF : 8'd0;
              argi_nxt = 2'd1;
            end else if (argi_r == 2'd1) begin
              if (size_r == 8'd0) begin
                size_nxt = rx_byte;
              end
              argi_nxt = 2'd2;
            end else begin
              mk_nxt    = (rx_byte == CH_FLASH) ? MK_FLASH :
                          (rx_byte == CH_EEPROM) ? MK_EEPROM : MK_OTHER;
              phase_nxt = PH_CMD;
              entry.mk  = mk_nxt;
              if (cmd_r == CH_BLOAD) begin
                if (!size_ok) begin
                  push       = 1'b1;
                  entry.kind = K_QM;
                end else begin
                  didx_nxt  = 8'd0;
                  phase_nxt = PH_DATA;
                end
              end else if (mk_nxt != MK_OTHER) begin
                push       = 1'b1;
                entry.kind = size_ok ? K_READ : K_QM;
              end
            end
          end
          PH_DATA: begin
            push       = 1'b1;
            entry.kind = K_DATA;
            entry.arg  = {8'd0, didx_r};
            entry.fin  = data_fin;
            didx_nxt   = didx_r + 8'd1;
            if (data_fin) begin
              phase_nxt = PH_CMD;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_WAIT_S;
      tick_r    <= '0;
      cmd_r     <= '0;
      argi_r    <= '0;
      size_r    <= '0;
      addr_hi_r <= '0;
      didx_r    <= '0;
      mk_r      <= MK_OTHER;
    end else begin
      phase_r   <= phase_nxt;
      tick_r    <= tick_nxt;
      cmd_r     <= cmd_nxt;
      argi_r    <= argi_nxt;
      size_r    <= size_nxt;
      addr_hi_r <= addr_hi_nxt;
      didx_r    <= didx_nxt;
      mk_r      <= mk_nxt;
    end
  end

endmodule

[hw/rtl/spce_back.sv]
`timescale 1ns / 1ps
module spce_back import spce_pkg::*; #(
  parameter int PAGE_BYTES   = PAGE_BYTES_DEF,
  parameter int FLASH_WORDS  = FLASH_WORDS_DEF,
  parameter int EEPROM_BYTES = EEPROM_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] app_end_bytes,
  input  cmd_t        cmd,
  input  logic        q_empty,
  output logic        pop,
  output logic        clr_done,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  byte_lo,
  output logic [7:0]  byte_hi,
  output logic [1:0]  byte_count,
  output logic        start_app,
  output logic        reset_request,
  output logic        last
);

  localparam int FW_AW = $clog2(FLASH_WORDS);
  localparam int EE_AW = $clog2(EEPROM_BYTES);
  localparam int PB_AW = $clog2(PAGE_BYTES);
  localparam int MAXD  = (FLASH_WORDS > EEPROM_BYTES) ? FLASH_WORDS : EEPROM_BYTES;
  localparam int CW    = $clog2(MAXD + 1);
  localparam logic [15:0] PB16 = 16'(PAGE_BYTES);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_SIG2, S_ERASE, S_FIN, S_WISS, S_WTAKE, S_RISS, S_RTAKE
  } state_t;

  state_t      state_r, state_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic [7:0]  j_r, j_nxt;
  logic [7:0]  size_r, size_nxt;
  mem_kind_t   mk_r, mk_nxt;
  logic [7:0]  lo_r, lo_nxt;
  logic [7:0]  ee_last_r, ee_last_nxt;
  logic        inrng_r, inrng_nxt;
  logic [CW-1:0] w_r, w_nxt;

  logic        ov_r, ov_nxt;
  logic [7:0]  olo_r, olo_nxt, ohi_r, ohi_nxt;
  logic [1:0]  ocnt_r, ocnt_nxt;
  logic        osa_r, osa_nxt, orr_r, orr_nxt, olast_r, olast_nxt;
  logic        can_emit;

  // memory ports
  logic             pb_we, pb_re;
  logic [PB_AW-1:0] pb_waddr, pb_raddr;
  logic [7:0]       pb_wdata, pb_q;
  logic             fl_we, fl_re;
  logic [FW_AW-1:0] fl_waddr, fl_raddr;
  logic [15:0]      fl_wdata, fl_q;
  logic             ee_we, ee_re;
  logic [EE_AW-1:0] ee_waddr, ee_raddr;
  logic [7:0]       ee_wdata, ee_q;

  logic [15:0] wa, ea;
  logic [17:0] pstart;
  logic [8:0]  j_inc1, j_inc2;

  function automatic logic flash_ok(input logic [15:0] w, input logic [15:0] app_end);
    flash_ok = ({w, 1'b0} < {1'b0, app_end}) && (17'(w) < 17'(FLASH_WORDS));
  endfunction

  assign can_emit   = !ov_r || out_ready;
  assign clr_done   = (state_r != S_CLR);
  assign out_valid  = ov_r;
  assign byte_lo    = olo_r;
  assign byte_hi    = ohi_r;
  assign byte_count = ocnt_r;
  assign start_app  = osa_r;
  assign reset_request = orr_r;
  assign last       = olast_r;

  assign wa     = addr_r + 16'(j_r >> 1);
  assign ea     = addr_r + 16'(j_r);
  assign pstart = (18'(w_r) << 1) & ~18'(PAGE_BYTES - 1);
  assign j_inc1 = {1'b0, j_r} + 9'd1;
  assign j_inc2 = {1'b0, j_r} + 9'd2;

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    addr_nxt    = addr_r;
    j_nxt       = j_r;
    size_nxt    = size_r;
    mk_nxt      = mk_r;
    lo_nxt      = lo_r;
    ee_last_nxt = ee_last_r;
    inrng_nxt   = inrng_r;
    w_nxt       = w_r;
    ov_nxt      = ov_r && !out_ready;
    olo_nxt     = olo_r;
    ohi_nxt     = ohi_r;
    ocnt_nxt    = ocnt_r;
    osa_nxt     = osa_r;
    orr_nxt     = orr_r;
    olast_nxt   = olast_r;
    pop         = 1'b0;
    pb_we = 1'b0; pb_waddr = cmd.arg[PB_AW-1:0]; pb_wdata = cmd.data;
    pb_re = 1'b0; pb_raddr = j_r[PB_AW-1:0];
    fl_we = 1'b0; fl_waddr = w_r[FW_AW-1:0]; fl_wdata = ERASED_W;
    fl_re = 1'b0; fl_raddr = wa[FW_AW-1:0];
    ee_we = 1'b0; ee_waddr = w_r[EE_AW-1:0]; ee_wdata = ERASED_B;
    ee_re = 1'b0; ee_raddr = ea[EE_AW-1:0];

    case (state_r)
      // erase both stores after reset
      S_CLR: begin
        fl_we = (w_r < CW'(FLASH_WORDS));
        ee_we = (w_r < CW'(EEPROM_BYTES));
        w_nxt = w_r + 1'b1;
        if (w_r == CW'(MAXD - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!q_empty && can_emit) begin
          pop = 1'b1;
          olo_nxt = CH_CR; ohi_nxt = 8'd0; ocnt_nxt = 2'd1;
          osa_nxt = 1'b0; orr_nxt = 1'b0; olast_nxt = 1'b1;
          case (cmd.kind)
            K_START: begin
              ov_nxt = 1'b1; olo_nxt = 8'd0; ocnt_nxt = 2'd0; osa_nxt = 1'b1;
            end
            K_CR: ov_nxt = 1'b1;
            K_QM: begin
              ov_nxt = 1'b1; olo_nxt = CH_QM;
            end
            K_EXIT: begin
              ov_nxt = 1'b1; orr_nxt = 1'b1;
            end
            K_ADDR: begin
              addr_nxt = cmd.arg;
              ov_nxt   = 1'b1;
            end
            K_SIG: begin
              ov_nxt = 1'b1; olo_nxt = SIG_BYTE; ohi_nxt = ee_last_r;
              ocnt_nxt = 2'd2; olast_nxt = 1'b0;
              state_nxt = S_SIG2;
            end
            K_ERASE: begin
              w_nxt = '0;
              state_nxt = S_ERASE;
            end
            K_DATA: begin
              pb_we = 1'b1;
              if (cmd.fin) begin
                size_nxt = cmd.size;
                mk_nxt   = cmd.mk;
                j_nxt    = 8'd0;
                if (cmd.mk == MK_OTHER) begin
                  ov_nxt = 1'b1;
                end else begin
                  state_nxt = S_WISS;
                end
              end
            end
            K_READ: begin
              size_nxt  = cmd.size;
              mk_nxt    = cmd.mk;
              j_nxt     = 8'd0;
              state_nxt = S_RISS;
            end
            default: begin
            end
          endcase
        end
      end
      S_SIG2: begin
        if (can_emit) begin
          ov_nxt = 1'b1; olo_nxt = PB16[15:8]; ohi_nxt = PB16[7:0];
          ocnt_nxt = 2'd2; olast_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      // pages below the loader region, one word a cycle
      S_ERASE: begin
        if (w_r < CW'(FLASH_WORDS) && pstart < 18'(app_end_bytes)) begin
          fl_we = 1'b1;
          w_nxt = w_r + 1'b1;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (can_emit) begin
          ov_nxt = 1'b1; olo_nxt = CH_CR; ohi_nxt = 8'd0; ocnt_nxt = 2'd1;
          osa_nxt = 1'b0; orr_nxt = 1'b0; olast_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      // block write, each buffer byte read in S_WISS and written in S_WTAKE
      S_WISS: begin
        pb_re = 1'b1;
        state_nxt = S_WTAKE;
      end
      S_WTAKE: begin
        if (mk_r == MK_FLASH) begin
          if (!j_r[0]) begin
            lo_nxt = pb_q;
          end else begin
            fl_we    = flash_ok(wa, app_end_bytes);
            fl_waddr = wa[FW_AW-1:0];
            fl_wdata = {pb_q, lo_r};
          end
        end else begin
          ee_we    = (17'(ea) < 17'(EEPROM_BYTES));
          ee_waddr = ea[EE_AW-1:0];
          ee_wdata = pb_q;
          if (ea == 16'(EEPROM_BYTES - 1)) begin
            ee_last_nxt = pb_q;
          end
        end
        j_nxt = j_inc1[7:0];
        if (j_inc1 >= {1'b0, size_r}) begin
          addr_nxt  = addr_r + ((mk_r == MK_FLASH) ? 16'(size_r >> 1) : 16'(size_r));
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_WISS;
        end
      end
      // block read
      S_RISS: begin
        if (mk_r == MK_FLASH) begin
          fl_re     = 1'b1;
          inrng_nxt = flash_ok(wa, app_end_bytes);
        end else begin
          ee_re     = 1'b1;
          inrng_nxt = (17'(ea) < 17'(EEPROM_BYTES));
        end
        state_nxt = S_RTAKE;
      end
      S_RTAKE: begin
        if (mk_r == MK_FLASH) begin
          if (can_emit) begin
            ov_nxt = 1'b1;
            olo_nxt = inrng_r ? fl_q[7:0] : ERASED_B;
            ohi_nxt = inrng_r ? fl_q[15:8] : ERASED_B;
            ocnt_nxt = 2'd2; osa_nxt = 1'b0; orr_nxt = 1'b0;
            olast_nxt = (j_inc2 >= {1'b0, size_r});
            j_nxt = j_inc2[7:0];
            if (j_inc2 >= {1'b0, size_r}) begin
              addr_nxt  = addr_r + 16'(size_r >> 1);
              state_nxt = S_IDLE;
            end else begin
              state_nxt = S_RISS;
            end
          end
        end else if (!j_r[0] && j_inc1 < {1'b0, size_r}) begin
          lo_nxt    = inrng_r ? ee_q : ERASED_B;
          j_nxt     = j_inc1[7:0];
          state_nxt = S_RISS;
        end else if (can_emit) begin
          ov_nxt = 1'b1; osa_nxt = 1'b0; orr_nxt = 1'b0;
          if (j_r[0]) begin
            olo_nxt = lo_r;
            ohi_nxt = inrng_r ? ee_q : ERASED_B;
            ocnt_nxt = 2'd2;
          end else begin
            olo_nxt = inrng_r ? ee_q : ERASED_B;
            ohi_nxt = 8'd0;
            ocnt_nxt = 2'd1;
          end
          olast_nxt = (j_inc1 >= {1'b0, size_r});
          j_nxt = j_inc1[7:0];
          if (j_inc1 >= {1'b0, size_r}) begin
            addr_nxt  = addr_r + 16'(size_r);
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_RISS;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      w_r       <= '0;
      ov_r      <= 1'b0;
      addr_r    <= '0;
      ee_last_r <= ERASED_B;
    end else begin
      state_r   <= state_nxt;
      w_r       <= w_nxt;
      ov_r      <= ov_nxt;
      addr_r    <= addr_nxt;
      ee_last_r <= ee_last_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    j_r     <= j_nxt;
    size_r  <= size_nxt;
    mk_r    <= mk_nxt;
    lo_r    <= lo_nxt;
    inrng_r <= inrng_nxt;
    olo_r   <= olo_nxt;
    ohi_r   <= ohi_nxt;
    ocnt_r  <= ocnt_nxt;
    osa_r   <= osa_nxt;
    orr_r   <= orr_nxt;
    olast_r <= olast_nxt;
  end

  // page buffer
  spce_ram #(.WIDTH(8), .DEPTH(PAGE_BYTES)) u_pbuf (
    .clk(clk), .we(pb_we), .waddr(pb_waddr), .wdata(pb_wdata),
    .re(pb_re), .raddr(pb_raddr), .rdata(pb_q)
  );

  // flash words
  spce_ram #(.WIDTH(16), .DEPTH(FLASH_WORDS)) u_flash (
    .clk(clk), .we(fl_we), .waddr(fl_waddr), .wdata(fl_wdata),
    .re(fl_re), .raddr(fl_raddr), .rdata(fl_q)
  );

  // eeprom bytes
  spce_ram #(.WIDTH(8), .DEPTH(EEPROM_BYTES)) u_eeprom (
    .clk(clk), .we(ee_we), .waddr(ee_waddr), .wdata(ee_wdata),
    .re(ee_re), .raddr(ee_raddr), .rdata(ee_q)
  );

endmodule

[hw/rtl/serial_programming_command_engine.sv]
`timescale 1ns / 1ps
// A request is accepted while in_tready is high and passes through the command queue; a simple
// result is then set up in the back end's output register. A flash block read issues each word
// in S_RISS and emits it in S_RTAKE; an eeprom read fetches up to two bytes per result.
// Block loads write the buffered bytes to memory at the end; erase writes one flash word per cycle below app_end.
// Reset is synchronous, active low; afterwards a clearing pass over
// max(FLASH_WORDS, EEPROM_BYTES) words (16384 by default) holds in_tready low.
module serial_programming_command_engine import spce_pkg::*; #(
  parameter int PAGE_BYTES   = PAGE_BYTES_DEF,
  parameter int FLASH_WORDS  = FLASH_WORDS_DEF,
  parameter int EEPROM_BYTES = EEPROM_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // rx_byte
  input  logic [0:0]  in_tuser,   // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // byte_lo, byte_hi, byte_count, start_app, reset_request
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  logic [15:0] timeout_r, app_end_r;
  logic        q_full, q_empty, push, pop, clr_done;
  cmd_t        q_in, q_out;
  logic [7:0]  byte_lo, byte_hi;
  logic [1:0]  byte_count;
  logic        start_app, reset_request;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RST;
      app_end_r <= APP_END_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_TIMEOUT: timeout_r <= cfg_wdata;
        CFG_APP_END: app_end_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  spce_front #(.PAGE_BYTES(PAGE_BYTES)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .rx_byte(in_tdata), .opcode(in_tuser[0]),
    .timeout_ticks(timeout_r),
    .q_full(q_full), .clr_done(clr_done),
    .push(push), .entry(q_in)
  );

  spce_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(push), .wdata(q_in), .full(q_full),
    .pop(pop), .rdata(q_out), .empty(q_empty)
  );

  spce_back #(
    .PAGE_BYTES(PAGE_BYTES), .FLASH_WORDS(FLASH_WORDS), .EEPROM_BYTES(EEPROM_BYTES)
  ) u_back (
    .clk(clk), .rst_n(rst_n),
    .app_end_bytes(app_end_r),
    .cmd(q_out), .q_empty(q_empty), .pop(pop), .clr_done(clr_done),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .byte_lo(byte_lo), .byte_hi(byte_hi), .byte_count(byte_count),
    .start_app(start_app), .reset_request(reset_request), .last(out_tlast)
  );

  assign out_tdata = {4'd0, reset_request, start_app, byte_count, byte_hi, byte_lo};

endmodule

[sim/tb_serial_programming_command_engine.sv]
`timescale 1ns / 1ps
module tb_serial_programming_command_engine;
  import spce_pkg::*;

  localparam int PAGE = PAGE_BYTES_DEF;
  localparam int FWORDS = FLASH_WORDS_DEF;
  localparam int EBYTES = EEPROM_BYTES_DEF;
  localparam int IDLE_LIMIT = 80000;
  localparam int SETTLE_CYCLES = 600;
  localparam logic [7:0] CH_OTHER = 8'h58;

  typedef enum int {ST_WAIT_S, ST_WAIT_ID, ST_LOCKED, ST_CMD, ST_ARGS, ST_DATA, ST_DONE} stage_t;

  typedef struct {
    logic [7:0] lo;
    logic [7:0] hi;
    logic [1:0] cnt;
    logic       sa;
    logic       rr;
    logic       last;
  } reply_t;

  // reply predictor and checker
  class spce_scoreboard;
    logic [15:0] timeout_ticks, app_end;
    stage_t      stage;
    logic [15:0] ticks, addr;
    logic [7:0]  cmd;
    int          argi;
    logic [7:0]  size;
    mem_kind_t   mk;
    logic [7:0]  didx;
    logic [7:0]  pbuf [PAGE];
    logic [15:0] flash [FWORDS];
    logic [7:0]  eeprom [EBYTES];
    reply_t      replies [$];
    int          errors, checked, requests;

    function new();
      timeout_ticks = TIMEOUT_RST;
      app_end = APP_END_RST;
      stage = ST_WAIT_S;
      ticks = 0; addr = 0; cmd = 0; argi = 0; size = 0; mk = MK_OTHER; didx = 0;
      foreach (pbuf[i]) pbuf[i] = ERASED_B;
      foreach (flash[i]) flash[i] = ERASED_W;
      foreach (eeprom[i]) eeprom[i] = ERASED_B;
      errors = 0; checked = 0; requests = 0;
    endfunction

    function void set_reg(logic idx, logic [15:0] v);
      if (idx == CFG_TIMEOUT) timeout_ticks = v;
      else app_end = v;
    endfunction

    function int pending();
      return replies.size();
    endfunction

    function void push(logic [7:0] lo, logic [7:0] hi, logic [1:0] cnt, logic sa, logic rr);
      reply_t r;
      r.lo = lo; r.hi = hi; r.cnt = cnt; r.sa = sa; r.rr = rr; r.last = 0;
      replies.push_back(r);
    endfunction

    function logic [15:0] flash_rd(logic [15:0] w);
      if ({w, 1'b0} < {1'b0, app_end} && w < FWORDS) return flash[w];
      return ERASED_W;
    endfunction

    function logic [7:0] ee_rd(logic [15:0] a);
      return (a < EBYTES) ? eeprom[a] : ERASED_B;
    endfunction

    function bit size_good();
      if (size == 0 || size > PAGE) return 0;
      if (mk == MK_FLASH && size[0]) return 0;
      return 1;
    endfunction

    function void load_block();
      logic [15:0] w;
      if (mk == MK_FLASH) begin
        for (int i = 0; i < size / 2; i++) begin
          w = addr + i;
          if ({w, 1'b0} < {1'b0, app_end} && w < FWORDS)
            flash[w] = {pbuf[2*i+1], pbuf[2*i]};
        end
        addr = addr + size / 2;
      end else if (mk == MK_EEPROM) begin
        for (int i = 0; i < size; i++) begin
          w = addr + i;
          if (w < EBYTES) eeprom[w] = pbuf[i];
        end
        addr = addr + size;
      end
    endfunction

    function void read_block();
      logic [15:0] d;
      if (mk == MK_FLASH) begin
        for (int i = 0; i < size / 2; i++) begin
          d = flash_rd(addr + i);
          push(d[7:0], d[15:8], 2, 0, 0);
        end
        addr = addr + size / 2;
      end else begin
        for (int i = 0; i < size; i += 2) begin
          if (i + 1 < size) push(ee_rd(addr + i), ee_rd(addr + i + 1), 2, 0, 0);
          else push(ee_rd(addr + i), 0, 1, 0, 0);
        end
        addr = addr + size;
      end
    endfunction

    function void erase_app();
      for (int w = 0; w < FWORDS; w++)
        if (((w * 2) / PAGE) * PAGE < app_end) flash[w] = ERASED_W;
    endfunction

    // advance the predicted state for one accepted request
    function void note_request(logic op, logic [7:0] b);
      int before_n;
      before_n = replies.size();
      requests++;
      if (stage == ST_WAIT_S) begin
        if (op == OP_TICK && ticks != 16'hFFFF) ticks++;
        if (ticks >= timeout_ticks) begin
          push(0, 0, 0, 1, 0);
          stage = ST_DONE;
        end else if (op == OP_BYTE && b == CH_START) begin
          stage = ST_WAIT_ID;
        end
      end else if (op == OP_TICK) begin
        // ticks only matter during the start wait
      end else if (stage == ST_WAIT_ID) begin
        if (b == eeprom[EBYTES-1] || b == 0) begin
          push(CH_CR, 0, 1, 0, 0);
          stage = ST_CMD;
        end else begin
          stage = ST_LOCKED;
        end
      end else if (stage == ST_CMD) begin
        if (b == CH_ADDR || b == CH_BLOAD || b == CH_BREAD) begin
          cmd = b; argi = 0; stage = ST_ARGS;
        end else if (b == CH_ERASE) begin
          erase_app();
          push(CH_CR, 0, 1, 0, 0);
        end else if (b == CH_EXIT) begin
          push(CH_CR, 0, 1, 0, 1);
          stage = ST_DONE;
        end else if (b == CH_SIG) begin
          push(SIG_BYTE, eeprom[EBYTES-1], 2, 0, 0);
          push(PAGE >> 8, PAGE & 8'hFF, 2, 0, 0);
        end else if (b != CH_ESC) begin
          push(CH_QM, 0, 1, 0, 0);
        end
      end else if (stage == ST_ARGS) begin
        if (cmd == CH_ADDR) begin
          if (argi == 0) begin
            addr = b; argi = 1;
          end else begin
            addr = {addr[7:0], b};
            push(CH_CR, 0, 1, 0, 0);
            stage = ST_CMD;
          end
        end else if (argi == 0) begin
          // nonzero high size byte means oversize
          size = (b != 0) ? 8'hFF : 8'h00;
          argi = 1;
        end else if (argi == 1) begin
          if (size == 0) size = b;
          argi = 2;
        end else begin
          mk = (b == CH_FLASH) ? MK_FLASH : (b == CH_EEPROM) ? MK_EEPROM : MK_OTHER;
          stage = ST_CMD;
          if (cmd == CH_BLOAD) begin
            if (!size_good()) push(CH_QM, 0, 1, 0, 0);
            else begin
              didx = 0; stage = ST_DATA;
            end
          end else if (mk != MK_OTHER) begin
            if (!size_good()) push(CH_QM, 0, 1, 0, 0);
            else read_block();
          end
        end
      end else if (stage == ST_DATA) begin
        if (didx < PAGE) pbuf[didx] = b;
        didx++;
        if (didx >= size) begin
          for (int i = size; i < PAGE; i++) pbuf[i] = ERASED_B;
          load_block();
          push(CH_CR, 0, 1, 0, 0);
          stage = ST_CMD;
        end
      end
      if (replies.size() > before_n) replies[replies.size()-1].last = 1;
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    // compare one accepted reply with the oldest prediction
    task check_response(logic [23:0] d, logic tl);
      reply_t e;
      if (replies.size() == 0) begin
        report($sformatf("unexpected reply data=%h last=%b", d, tl));
        return;
      end
      e = replies.pop_front();
      checked++;
      if (d[7:0] !== e.lo) report($sformatf("byte_lo %h exp %h", d[7:0], e.lo));
      if (d[15:8] !== e.hi) report($sformatf("byte_hi %h exp %h", d[15:8], e.hi));
      if (d[17:16] !== e.cnt) report($sformatf("byte_count %0d exp %0d", d[17:16], e.cnt));
      if (d[18] !== e.sa) report($sformatf("start_app %b exp %b", d[18], e.sa));
      if (d[19] !== e.rr) report($sformatf("reset_request %b exp %b", d[19], e.rr));
      if (d[23:20] !== 4'b0) report($sformatf("pad bits %h not zero", d[23:20]));
      if (tl !== e.last) report($sformatf("last %b exp %b", tl, e.last));
    endtask
  endclass

  logic        clk, rst_n;
  logic        in_tvalid, in_tready;
  logic [7:0]  in_tdata;   // rx_byte
  logic [0:0]  in_tuser;   // opcode
  logic        out_tvalid, out_tready;
  logic [23:0] out_tdata;  // byte_lo, byte_hi, byte_count, start_app, reset_request
  logic        out_tlast;
  logic        cfg_wr_en;
  logic [0:0]  cfg_index;
  logic [15:0] cfg_wdata;

  spce_scoreboard sb;
  int  sent;
  int  tx_burst, rx_burst;
  int  idle_cycles;
  bit  squeeze_done;

  serial_programming_command_engine DUT (.*);

  // clock
  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // mostly short gaps, a few long ones, with stretches of none
  function automatic int pick_gap(ref int burst);
    int r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) burst = $urandom_range(10, 40);
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // offer one request and wait for its handshake
  task automatic send(logic op, logic [7:0] b);
    int g;
    g = pick_gap(tx_burst);
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= b;
    do @(posedge clk); while (!in_tready);
    sb.note_request(op, b);
    sent++;
  endtask

  task automatic send_byte(logic [7:0] b);
    send(OP_BYTE, b);
  endtask

  // let every prediction drain and the back end go quiet
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(logic idx, logic [15:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_reg(idx, v);
  endtask

  task automatic set_addr(logic [15:0] a);
    send_byte(CH_ADDR);
    send_byte(a[15:8]);
    send_byte(a[7:0]);
  endtask

  task automatic block_load(logic [15:0] sz, logic [7:0] kind, int nbytes);
    send_byte(CH_BLOAD);
    send_byte(sz[15:8]);
    send_byte(sz[7:0]);
    send_byte(kind);
    for (int i = 0; i < nbytes; i++) send_byte($urandom_range(0, 255));
  endtask

  task automatic block_read(logic [15:0] sz, logic [7:0] kind);
    send_byte(CH_BREAD);
    send_byte(sz[15:8]);
    send_byte(sz[7:0]);
    send_byte(kind);
  endtask

  // data byte count the block will actually take for a load
  function automatic int load_len(logic [15:0] sz, logic [7:0] kind);
    if (sz == 0 || sz > PAGE) return 0;
    if (kind == CH_FLASH && sz[0]) return 0;
    return sz;
  endfunction

  function automatic logic [15:0] pick_addr();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return (sb.app_end >> 1) - 16'($urandom_range(0, 40)) + 16'($urandom_range(0, 40));
    if (r < 60) return 16'($urandom_range(EBYTES - 40, EBYTES + 20));
    if (r < 85) return 16'($urandom_range(0, 300));
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [15:0] pick_size(logic [7:0] kind);
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return 0;
    if (r < 10) return 16'($urandom_range(PAGE + 1, 65535));
    if (r < 15) return PAGE;
    if (kind == CH_FLASH && r < 92) return 16'($urandom_range(1, 8) * 2);
    return 16'($urandom_range(1, 16));
  endfunction

  function automatic logic [7:0] pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return CH_FLASH;
    if (r < 90) return CH_EEPROM;
    return CH_OTHER + 8'($urandom_range(0, 3));
  endfunction

  // stray byte that cannot open a command or end the session
  function automatic logic [7:0] pick_noise();
    logic [7:0] b;
    do b = $urandom_range(0, 255);
    while (b == CH_ADDR || b == CH_BLOAD || b == CH_BREAD || b == CH_EXIT || b == CH_ERASE);
    return b;
  endfunction

  // reply side, with one long hold-off so the block backs up
  initial begin
    int g;
    out_tready = 1'b0;
    squeeze_done = 0;
    forever begin
      if (!squeeze_done && sent >= 150) begin
        out_tready <= 1'b0;
        repeat (500) @(posedge clk);
        squeeze_done = 1;
      end else begin
        g = pick_gap(rx_burst);
        if (g > 0) begin
          out_tready <= 1'b0;
          repeat (g) @(posedge clk);
        end
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // reply monitor
  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready) sb.check_response(out_tdata, out_tlast);

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int r;
    logic [7:0] kind;
    logic [15:0] sz;
    sb = new();
    sent = 0; tx_burst = 0; rx_burst = 0; idle_cycles = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0; in_tdata = 0; in_tuser = 0;
    cfg_wr_en = 1'b0; cfg_index = 0; cfg_wdata = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // keep the start wait open, then log in
    reg_write(CFG_TIMEOUT, 16'hFFFF);
    reg_write(CFG_APP_END, 16'h8000);
    send(OP_TICK, 8'hA5);
    send_byte(8'h00);
    send_byte(8'hFF);
    send(OP_TICK, 8'h5A);
    send_byte(CH_START);
    send(OP_TICK, 8'h00);
    send_byte(8'hFF);

    // directed commands
    send_byte(CH_SIG);
    send_byte(CH_ESC);
    send_byte(8'h00);
    set_addr(16'h0000);
    block_load(4, CH_FLASH, 4);
    set_addr(16'h0000);
    block_read(4, CH_FLASH);
    set_addr(16'd1022);
    block_load(3, CH_EEPROM, 3);
    set_addr(16'd1022);
    block_read(3, CH_EEPROM);
    send_byte(CH_SIG);
    block_load(0, CH_FLASH, 0);
    block_load(PAGE + 1, CH_EEPROM, 0);
    block_load(16'h0102, CH_EEPROM, 0);
    block_read(16'h0100, CH_FLASH);
    block_load(5, CH_FLASH, 0);
    block_load(2, CH_OTHER, 2);
    block_read(4, CH_OTHER);
    set_addr(16'hFFFF);
    block_read(4, CH_EEPROM);
    set_addr(16'h3FC0);
    block_load(PAGE, CH_FLASH, PAGE);
    set_addr(16'h3FC0);
    block_read(PAGE, CH_FLASH);
    settle();

    reg_write(CFG_APP_END, 16'h0000);
    reg_write(CFG_TIMEOUT, 16'h0000);
    send_byte(CH_ERASE);
    set_addr(16'h0000);
    block_load(8, CH_FLASH, 8);
    set_addr(16'h0000);
    block_read(8, CH_FLASH);
    settle();
    reg_write(CFG_APP_END, APP_END_RST);
    send_byte(CH_ERASE);

    // random command sequences with some noise and ticks
    while (sent < 430) begin
      if (sent > 200 && sent < 215) begin
        settle();
        reg_write(CFG_APP_END, 16'($urandom_range(0, 32768)));
        reg_write(CFG_TIMEOUT, 16'($urandom_range(0, 65535)));
      end
      r = $urandom_range(0, 99);
      if (r < 20) set_addr(pick_addr());
      else if (r < 48) begin
        kind = pick_kind();
        sz = pick_size(kind);
        block_load(sz, kind, load_len(sz, kind));
      end else if (r < 73) begin
        kind = pick_kind();
        block_read(pick_size(kind), kind);
      end else if (r < 79) send_byte(CH_SIG);
      else if (r < 81) send_byte(CH_ERASE);
      else if (r < 90) send_byte(pick_noise());
      else send(OP_TICK, $urandom_range(0, 255));
    end

    // session end, then everything is ignored
    settle();
    send_byte(CH_EXIT);
    send_byte(CH_SIG);
    send(OP_TICK, 8'h00);
    send_byte(CH_ADDR);
    settle();

    $display("covered %0d requests and %0d checked replies", sb.requests, sb.checked);
    $display("login, address, block load and read, erase, signature, errors, exit");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
